[sv/voxel_face_cull_mesher_macros.svh]
// Assertion macros for the voxel face culling mesher.
// Used by the top level only; depends on nothing.
`ifndef VOXEL_FACE_CULL_MESHER_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_MACROS_SVH
`define VFC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/vfc_pkg.sv]
// Shared constants, types and tables for the voxel face culling mesher.
// Depends on nothing.
package vfc_pkg;
  localparam int ChunkWidth = 16;
  localparam int ChunkHeight = 64;
  localparam int TypeCount = 256;
  localparam int XW = 4;
  localparam int YW = 6;
  localparam int ZW = 4;
  localparam int VoxAw = XW + YW + ZW;
  localparam int PlaneAw = 3 + 4 + 6;
  localparam int UvAw = 8 + 3 + 2;
  localparam int QuadW = 17;

  localparam logic [2:0] CMD_LOAD_VOXEL = 3'd0;
  localparam logic [2:0] CMD_LOAD_PLANE = 3'd1;
  localparam logic [2:0] CMD_LOAD_UV = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_MESH = 3'd4;

  // Members run from the highest bit down, so command lands in the lowest bits.
  typedef struct packed {
    logic [15:0] v;
    logic [15:0] u;
    logic [7:0] vtype;
    logic [1:0] corner;
    logic [2:0] face;
    logic [ZW-1:0] z;
    logic [YW-1:0] y;
    logic [XW-1:0] x;
    logic [2:0] command;
  } cmd_t;

  typedef struct packed {
    logic [4:0] vx;
    logic [6:0] vy;
    logic [4:0] vz;
    logic [15:0] tu;
    logic [15:0] tv;
    logic [2:0] face;
    logic [1:0] corner;
    logic [QuadW-1:0] quad;
    logic last;
  } vert_t;

  function automatic logic [2:0] corner_off(input logic [2:0] f, input logic [1:0] c);
    logic [11:0] row;
    row = 12'd0;
    case (f)
      3'd0: row = {3'd1, 3'd3, 3'd2, 3'd0};
      3'd1: row = {3'd4, 3'd6, 3'd7, 3'd5};
      3'd2: row = {3'd0, 3'd2, 3'd6, 3'd4};
      3'd3: row = {3'd5, 3'd7, 3'd3, 3'd1};
      3'd4: row = {3'd5, 3'd1, 3'd0, 3'd4};
      3'd5: row = {3'd6, 3'd2, 3'd3, 3'd7};
      default: row = 12'd0;
    endcase
    return row[c*3 +: 3];
  endfunction
endpackage

[sv/vfc_store.sv]
// Voxel, neighbor plane and UV memories with registered reads.
// Depends on vfc_pkg. Plane memory is cleared by a sweep after reset.
module vfc_store import vfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vox_we,
  input  logic [VoxAw-1:0] vox_wa,
  input  logic [7:0] vox_wd,
  input  logic [VoxAw-1:0] vox_ra,
  output logic [7:0] vox_rd,
  input  logic pl_we,
  input  logic [PlaneAw-1:0] pl_wa,
  input  logic [7:0] pl_wd,
  input  logic [PlaneAw-1:0] pl_ra,
  output logic [7:0] pl_rd,
  input  logic uv_we,
  input  logic [UvAw-1:0] uv_wa,
  input  logic [31:0] uv_wd,
  input  logic [UvAw-1:0] uv_ra,
  output logic [31:0] uv_rd,
  output logic clearing
);
  logic [7:0] vox_mem [0:(1<<VoxAw)-1];
  logic [7:0] pl_mem [0:(1<<PlaneAw)-1];
  logic [31:0] uv_mem [0:(1<<UvAw)-1];
  logic [PlaneAw:0] clr;

  assign clearing = !clr[PlaneAw];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (clearing) begin
      clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_wa] <= vox_wd;
    vox_rd <= vox_mem[vox_ra];
  end

  always_ff @(posedge clk) begin
    if (clearing) pl_mem[clr[PlaneAw-1:0]] <= 8'd0;
    else if (pl_we) pl_mem[pl_wa] <= pl_wd;
    pl_rd <= pl_mem[pl_ra];
  end

  always_ff @(posedge clk) begin
    if (uv_we) uv_mem[uv_wa] <= uv_wd;
    uv_rd <= uv_mem[uv_ra];
  end
endmodule

[sv/voxel_face_cull_mesher.sv]
// Channel | dir | tdata fields (low bit first)                       | tuser
// s_axis  | in  | command,x,y,z,face_sel,corner_sel,voxel_type,u,v    | none
// m_axis  | out | vert_x,vert_y,vert_z,tex_u,tex_v,face,corner,quad   | tlast=last
// cfg     | in  | world_mode                                          | none
// Load and clear words leave the sequencer idle. A mesh word reads its own voxel,
// then, if it is solid, each of the six neighbors in turn, then the UV entry of
// each emitted vertex; every one of these reads goes through a registered port.
// After reset the plane memory is cleared entry by entry; no word is taken then.
// A finished vertex waits in the output register while the receiver stalls, and the
// sequencer holds until that register is free.
module voxel_face_cull_mesher import vfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata, // command,x,y,z,face,corner,type,u,v
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [71:0] m_axis_tdata, // vx,vy,vz,tu,tv,face,corner,quad
  output logic m_axis_tlast
);
`include "voxel_face_cull_mesher_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SELF = 6'b000010, S_NREQ = 6'b000100,
    S_NCHK = 6'b001000, S_UVRD = 6'b010000, S_EMIT = 6'b100000
  } state_t;

  state_t state;
  cmd_t c, in;
  logic world_mode;
  logic [QuadW-1:0] quad_count;
  logic [2:0] face;
  logic [1:0] corner;
  logic [7:0] self_type;
  logic edge_vox;
  logic clearing;
  logic vox_we, pl_we, uv_we;
  logic [VoxAw-1:0] vox_ra;
  logic [PlaneAw-1:0] pl_ra, pl_wa;
  logic [UvAw-1:0] uv_ra;
  logic [7:0] vox_rd, pl_rd;
  logic [31:0] uv_rd;
  logic use_plane, at_edge;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic [ZW-1:0] nz;
  logic [2:0] off;
  logic [15:0] tu, tv;
  logic last_face, n_empty;
  logic [5:0] empty_mask, mask_now;
  logic [2:0] first_face, next_face;
  logic has_first, has_next;
  vert_t ov;

  assign in = s_axis_tdata[61:0];
  assign s_axis_tready = (state == S_IDLE) && !clearing;
  wire take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (in.face)
      3'd0, 3'd1: pl_wa = {in.face, in.x, in.y};
      3'd2, 3'd3: pl_wa = {in.face, in.z, in.y};
      default: pl_wa = {in.face, in.x, 2'b00, in.z};
    endcase
  end
  assign vox_we = take && in.command == CMD_LOAD_VOXEL;
  assign pl_we = take && in.command == CMD_LOAD_PLANE && in.face < 3'd6;
  assign uv_we = take && in.command == CMD_LOAD_UV && in.face < 3'd6;

  always_comb begin
    nx = c.x; ny = c.y; nz = c.z; at_edge = 1'b0;
    case (face)
      3'd0: begin at_edge = c.z == ZW'(ChunkWidth-1); nz = c.z + 1'b1; end
      3'd1: begin at_edge = c.z == '0; nz = c.z - 1'b1; end
      3'd2: begin at_edge = c.x == XW'(ChunkWidth-1); nx = c.x + 1'b1; end
      3'd3: begin at_edge = c.x == '0; nx = c.x - 1'b1; end
      3'd4: begin at_edge = c.y == YW'(ChunkHeight-1); ny = c.y + 1'b1; end
      default: begin at_edge = c.y == '0; ny = c.y - 1'b1; end
    endcase
    case (face)
      3'd0, 3'd1: pl_ra = {face, c.x, c.y};
      3'd2, 3'd3: pl_ra = {face, c.z, c.y};
      default: pl_ra = {face, c.x, 2'b00, c.z};
    endcase
    if (state == S_IDLE) vox_ra = {in.x, in.y, in.z};
    else if (state == S_NREQ) vox_ra = {nx, ny, nz};
    else vox_ra = {c.x, c.y, c.z};
    uv_ra = {self_type, face, corner};
  end

  vfc_store u_store (
    .clk, .rst, .vox_we, .vox_wa({in.x, in.y, in.z}), .vox_wd(in.vtype), .vox_ra,
    .vox_rd, .pl_we, .pl_wa, .pl_wd(in.vtype), .pl_ra, .pl_rd, .uv_we,
    .uv_wa({in.vtype, in.face, in.corner}), .uv_wd({in.v, in.u}), .uv_ra, .uv_rd,
    .clearing
  );

  assign n_empty = use_plane ? (!world_mode || pl_rd == 8'd0) : (vox_rd == 8'd0);
  assign last_face = face == 3'd5;
  assign off = corner_off(face, corner);
  assign mask_now = {n_empty, empty_mask[4:0]};

  // All six neighbors are checked before the first vertex leaves, so the final
  // vertex of the word is known when it is built.
  always_comb begin
    first_face = 3'd0;
    has_first = 1'b0;
    next_face = face;
    has_next = 1'b0;
    for (int i = 5; i >= 0; i--) begin
      if (mask_now[i]) begin
        first_face = 3'(i);
        has_first = 1'b1;
      end
      if (empty_mask[i] && 3'(i) > face) begin
        next_face = 3'(i);
        has_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (edge_vox && !world_mode) begin
      tu = corner[1] ? 16'h0000 : 16'h8000;
      tv = (corner == 2'd0 || corner == 2'd3) ? 16'h8000 : 16'h0000;
    end else begin
      tu = uv_rd[15:0];
      tv = uv_rd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      world_mode <= 1'b1;
      quad_count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) world_mode <= cfg_wdata;
      if (state == S_EMIT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (take) begin
          c <= in;
          if (in.command == CMD_CLEAR) quad_count <= '0;
          if (in.command == CMD_MESH) state <= S_SELF;
        end
        S_SELF: begin
          self_type <= vox_rd;
          edge_vox <= c.x == '0 || c.x == XW'(ChunkWidth-1) || c.y == '0 ||
                      c.y == YW'(ChunkHeight-1) || c.z == '0 || c.z == ZW'(ChunkWidth-1);
          face <= 3'd0;
          empty_mask <= '0;
          state <= (vox_rd == 8'd0) ? S_IDLE : S_NREQ;
        end
        S_NREQ: begin
          use_plane <= at_edge;
          corner <= 2'd0;
          state <= S_NCHK;
        end
        S_NCHK: begin
          empty_mask[face] <= n_empty;
          if (!last_face) begin
            face <= face + 1'b1; state <= S_NREQ;
          end else if (has_first) begin
            face <= first_face; state <= S_UVRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_UVRD: if (!m_axis_tvalid || m_axis_tready) state <= S_EMIT;
        S_EMIT: begin
          ov.vx <= {1'b0, c.x} - 5'(off[0]);
          ov.vy <= {1'b0, c.y} - 7'(off[1]);
          ov.vz <= {1'b0, c.z} - 5'(off[2]);
          ov.tu <= tu;
          ov.tv <= tv;
          ov.face <= face;
          ov.corner <= corner;
          ov.quad <= quad_count;
          ov.last <= corner == 2'd3 && !has_next;
          corner <= corner + 1'b1;
          if (corner != 2'd3) begin
            state <= S_UVRD;
          end else begin
            quad_count <= quad_count + 1'b1;
            if (has_next) begin
              face <= next_face; state <= S_UVRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, ov.quad, ov.corner, ov.face, ov.tv, ov.tu, ov.vz,
                         ov.vy, ov.vx};
  assign m_axis_tlast = ov.last;

  `VFC_ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready, state == S_IDLE)
  `VFC_ASSERT_NEXT(a_clear, clk, rst, take && in.command == CMD_CLEAR, quad_count == '0)
  `VFC_ASSERT_IMPL(a_emit_room, clk, rst, state == S_EMIT, !m_axis_tvalid)
  `VFC_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

[tb/sv/tb_voxel_face_cull_mesher.sv]
// Self-checking testbench for voxel_face_cull_mesher: a directed table and a
// constrained random sweep in both world modes, each checked against a local predictor.
// Depends on vfc_pkg and the voxel_face_cull_mesher RTL.
module tb_voxel_face_cull_mesher;
  timeunit 1ns;
  timeprecision 1ps;
  import vfc_pkg::*;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_NZ = 3'd1;
  localparam logic [2:0] FACE_PX = 3'd2;
  localparam logic [2:0] FACE_NX = 3'd3;
  localparam logic [2:0] FACE_PY = 3'd4;
  localparam logic [2:0] FACE_NY = 3'd5;
  localparam logic [2:0] FACE_BAD = 3'd6;
  localparam logic [2:0] FACE_BAD7 = 3'd7;
  localparam int PlaneSpan = 64;
  localparam int CycleLimit = 3000000;
  localparam int NoCount = -1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic m_axis_tlast;

  voxel_face_cull_mesher i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's stores.
  logic [7:0] vox_mirror [ChunkWidth*ChunkHeight*ChunkWidth];
  bit vox_known [ChunkWidth*ChunkHeight*ChunkWidth];
  logic [7:0] plane_mirror [6][ChunkWidth*PlaneSpan];
  logic [31:0] uv_mirror [TypeCount*24];
  bit uv_ready [TypeCount];
  logic [QuadW-1:0] quad_mirror;
  logic world_mode;

  vert_t vertex_queue[$];
  int errors = 0;
  int words_sent = 0;
  int verts_seen = 0;
  int meshes_sent = 0;
  int cycles = 0;
  int phase = 0;
  bit long_hold_done = 1'b0;

  // Corner offsets per face: bit0 x-1, bit1 y-1, bit2 z-1.
  const logic [2:0] corner_offset [6][4] = '{
    '{3'd0, 3'd2, 3'd3, 3'd1}, '{3'd5, 3'd7, 3'd6, 3'd4},
    '{3'd4, 3'd6, 3'd2, 3'd0}, '{3'd1, 3'd3, 3'd7, 3'd5},
    '{3'd4, 3'd0, 3'd1, 3'd5}, '{3'd7, 3'd3, 3'd2, 3'd6}};

  function automatic int vox_addr(int x, int y, int z);
    return (x * ChunkHeight + y) * ChunkWidth + z;
  endfunction

  function automatic int plane_addr(logic [2:0] f, int x, int y, int z);
    if (f < FACE_PX) return x * PlaneSpan + y;
    if (f < FACE_PY) return z * PlaneSpan + y;
    return x * PlaneSpan + z;
  endfunction

  function automatic logic [7:0] neighbor_of(logic [2:0] f, int x, int y, int z);
    bit at_edge;
    int nx, ny, nz;
    nx = x; ny = y; nz = z;
    case (f)
      FACE_PZ: begin at_edge = (z == ChunkWidth-1); nz = z + 1; end
      FACE_NZ: begin at_edge = (z == 0); nz = z - 1; end
      FACE_PX: begin at_edge = (x == ChunkWidth-1); nx = x + 1; end
      FACE_NX: begin at_edge = (x == 0); nx = x - 1; end
      FACE_PY: begin at_edge = (y == ChunkHeight-1); ny = y + 1; end
      default: begin at_edge = (y == 0); ny = y - 1; end
    endcase
    if (!at_edge) return vox_mirror[vox_addr(nx, ny, nz)];
    if (!world_mode) return 8'd0;
    return plane_mirror[f][plane_addr(f, x, y, z)];
  endfunction

  // Applies one accepted word to the mirror and queues the vertices it yields.
  function automatic int predict_vertices(cmd_t w);
    int x, y, z, n;
    logic [7:0] self_t;
    bit fixed_uv;
    logic [2:0] o;
    logic [31:0] e;
    vert_t vt;
    x = w.x; y = w.y; z = w.z; n = 0;
    case (w.command)
      CMD_LOAD_VOXEL: begin
        vox_mirror[vox_addr(x, y, z)] = w.vtype;
        vox_known[vox_addr(x, y, z)] = 1'b1;
      end
      CMD_LOAD_PLANE:
        if (w.face < 3'd6) plane_mirror[w.face][plane_addr(w.face, x, y, z)] = w.vtype;
      CMD_LOAD_UV:
        if (w.face < 3'd6) uv_mirror[(w.vtype * 6 + w.face) * 4 + w.corner] = {w.v, w.u};
      CMD_CLEAR: quad_mirror = '0;
      CMD_MESH: begin
        self_t = vox_mirror[vox_addr(x, y, z)];
        fixed_uv = !world_mode && (x == 0 || x == ChunkWidth-1 || y == 0 ||
                   y == ChunkHeight-1 || z == 0 || z == ChunkWidth-1);
        if (self_t != 8'd0) begin
          for (int f = 0; f < 6; f++) begin
            if (neighbor_of(3'(f), x, y, z) == 8'd0) begin
              for (int c = 0; c < 4; c++) begin
                o = corner_offset[f][c];
                e = uv_mirror[(self_t * 6 + f) * 4 + c];
                if (fixed_uv) begin
                  vt.tu = (c < 2) ? 16'h8000 : 16'h0000;
                  vt.tv = (c == 0 || c == 3) ? 16'h8000 : 16'h0000;
                end else begin
                  vt.tu = e[15:0];
                  vt.tv = e[31:16];
                end
                vt.vx = 5'(x - o[0]);
                vt.vy = 7'(y - o[1]);
                vt.vz = 5'(z - o[2]);
                vt.face = 3'(f);
                vt.corner = 2'(c);
                vt.quad = quad_mirror;
                vt.last = 1'b0;
                vertex_queue.push_back(vt);
                n++;
              end
              quad_mirror = quad_mirror + 1'b1;
            end
          end
          if (n > 0) vertex_queue[$].last = 1'b1;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input cmd_t w, output int n);
    int gap;
    s_axis_tdata <= {2'b00, w.v, w.u, w.vtype, w.corner, w.face, w.z, w.y, w.x, w.command};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    n = predict_vertices(w);
    words_sent++;
    if (w.command == CMD_MESH) meshes_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cmd_t make_word(logic [2:0] c, int x, int y, int z, logic [2:0] f,
                                     logic [1:0] cr, logic [7:0] t, logic [15:0] u,
                                     logic [15:0] v);
    cmd_t w;
    w.command = c; w.x = 4'(x); w.y = 6'(y); w.z = 4'(z);
    w.face = f; w.corner = cr; w.vtype = t; w.u = u; w.v = v;
    return w;
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd128;
      4: return 8'd255;
      default: return 8'd3;
    endcase
  endfunction

  // Every solid type gets a full set of texture coordinates before it is stored.
  task automatic load_voxel(int x, int y, int z, logic [7:0] t);
    int n;
    if (t != 8'd0 && !uv_ready[t]) begin
      for (int f = 0; f < 6; f++)
        for (int c = 0; c < 4; c++)
          send_word(make_word(CMD_LOAD_UV, $urandom_range(0, 15), $urandom_range(0, 63),
                              $urandom_range(0, 15), 3'(f), 2'(c), t,
                              16'($urandom), 16'($urandom)), n);
      uv_ready[t] = 1'b1;
    end
    send_word(make_word(CMD_LOAD_VOXEL, x, y, z, 3'($urandom), 2'($urandom), t,
                        16'($urandom), 16'($urandom)), n);
  endtask

  // Fills the target and its in-chunk neighbors so that a mesh word reads no unwritten entry.
  task automatic fill_around(int x, int y, int z, bit random_fill);
    int nx, ny, nz;
    if (!vox_known[vox_addr(x, y, z)]) load_voxel(x, y, z, random_fill ? pick_type() : 8'd1);
    for (int f = 0; f < 6; f++) begin
      nx = x; ny = y; nz = z;
      case (3'(f))
        FACE_PZ: nz = z + 1;
        FACE_NZ: nz = z - 1;
        FACE_PX: nx = x + 1;
        FACE_NX: nx = x - 1;
        FACE_PY: ny = y + 1;
        default: ny = y - 1;
      endcase
      if (nx >= 0 && nx < ChunkWidth && ny >= 0 && ny < ChunkHeight &&
          nz >= 0 && nz < ChunkWidth && !vox_known[vox_addr(nx, ny, nz)])
        load_voxel(nx, ny, nz, (random_fill && $urandom_range(0, 2) == 0) ? pick_type() : 8'd0);
    end
  endtask

  task automatic write_mode(logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    world_mode = m;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (vertex_queue.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int pick_coord(int hi);
    if ($urandom_range(0, 1)) return ($urandom_range(0, 1)) ? 0 : hi;
    return $urandom_range(0, hi);
  endfunction

  typedef struct {
    logic [2:0] c;
    int x, y, z;
    logic [2:0] f;
    logic [1:0] cr;
    logic [7:0] t;
    logic [15:0] u, v;
    int count;
  } row_t;

  row_t directed [] = '{
    '{CMD_CLEAR, 0, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 0},
    '{CMD_LOAD_VOXEL, 0, 0, 0, FACE_PZ, 2'd0, 8'd1, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 0, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 24},
    '{CMD_LOAD_PLANE, 0, 0, 0, FACE_NZ, 2'd0, 8'd7, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 0, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 20},
    '{CMD_LOAD_VOXEL, 15, 63, 15, FACE_PZ, 2'd3, 8'd255, 16'hFFFF, 16'hFFFF, 0},
    '{CMD_MESH, 15, 63, 15, FACE_NY, 2'd3, 8'd255, 16'hFFFF, 16'hFFFF, 24},
    '{CMD_LOAD_VOXEL, 5, 30, 5, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 5, 30, 5, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 0},
    '{CMD_LOAD_UV, 9, 9, 9, FACE_NY, 2'd3, 8'd255, 16'hFFFF, 16'h0000, 0},
    '{CMD_LOAD_UV, 9, 9, 9, FACE_BAD7, 2'd1, 8'd255, 16'h1234, 16'h5678, 0},
    '{CMD_LOAD_PLANE, 3, 3, 3, FACE_BAD, 2'd0, 8'd9, 16'h0000, 16'h0000, 0},
    '{CMD_RSVD5, 1, 1, 1, FACE_PZ, 2'd0, 8'd1, 16'h0000, 16'h0000, 0},
    '{CMD_RSVD6, 1, 1, 1, FACE_PZ, 2'd0, 8'd1, 16'h0000, 16'h0000, 0},
    '{CMD_RSVD7, 15, 63, 15, FACE_BAD7, 2'd3, 8'd255, 16'hFFFF, 16'hFFFF, 0},
    '{CMD_LOAD_VOXEL, 1, 0, 0, FACE_PZ, 2'd0, 8'd2, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 1, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 20},
    '{CMD_MESH, 0, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 16},
    '{CMD_LOAD_PLANE, 15, 63, 15, FACE_PY, 2'd0, 8'd255, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 15, 63, 15, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 20},
    '{CMD_CLEAR, 0, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, 0},
    '{CMD_MESH, 1, 0, 0, FACE_PZ, 2'd0, 8'd0, 16'h0000, 16'h0000, NoCount}
  };

  task automatic random_word();
    int r, n, x, y, z;
    r = $urandom_range(0, 99);
    x = pick_coord(ChunkWidth-1);
    y = pick_coord(ChunkHeight-1);
    z = pick_coord(ChunkWidth-1);
    if (r < 55) begin
      fill_around(x, y, z, 1'b1);
      send_word(make_word(CMD_MESH, x, y, z, 3'($urandom), 2'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom)), n);
    end else if (r < 72) begin
      load_voxel(x, y, z, pick_type());
    end else if (r < 84) begin
      send_word(make_word(CMD_LOAD_PLANE, x, y, z, 3'($urandom), 2'($urandom),
                          ($urandom_range(0, 1)) ? 8'd0 : pick_type(),
                          16'($urandom), 16'($urandom)), n);
    end else if (r < 92) begin
      send_word(make_word(CMD_LOAD_UV, x, y, z, 3'($urandom), 2'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom)), n);
    end else if (r < 96) begin
      send_word(make_word(CMD_CLEAR, x, y, z, 3'($urandom), 2'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom)), n);
    end else begin
      send_word(make_word(3'($urandom_range(5, 7)), x, y, z, 3'($urandom), 2'($urandom),
                          8'($urandom), 16'($urandom), 16'($urandom)), n);
    end
  endtask

  // Receiver readiness; one long hold-off in the second phase fills the block up.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (phase == 2 && !long_hold_done) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    vert_t got, want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("voxel_face_cull_mesher regression: fail");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.vx = m_axis_tdata[4:0];
      got.vy = m_axis_tdata[11:5];
      got.vz = m_axis_tdata[16:12];
      got.tu = m_axis_tdata[32:17];
      got.tv = m_axis_tdata[48:33];
      got.face = m_axis_tdata[51:49];
      got.corner = m_axis_tdata[53:52];
      got.quad = m_axis_tdata[70:54];
      got.last = m_axis_tlast;
      verts_seen++;
      if (vertex_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex word %h", m_axis_tdata);
      end else begin
        want = vertex_queue.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.tu !== want.tu || got.tv !== want.tv || got.face !== want.face ||
            got.corner !== want.corner || got.quad !== want.quad ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("vertex mismatch: expected pos %0d,%0d,%0d uv %h,%h ",
                     $signed(want.vx), $signed(want.vy), $signed(want.vz),
                     want.tu, want.tv,
                     "face %0d corner %0d quad %0d last %0b; ",
                     want.face, want.corner, want.quad, want.last,
                     "got pos %0d,%0d,%0d uv %h,%h ",
                     $signed(got.vx), $signed(got.vy), $signed(got.vz), got.tu, got.tv,
                     "face %0d corner %0d quad %0d last %0b",
                     got.face, got.corner, got.quad, got.last);
        end
      end
    end
  end

  initial begin
    int n;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    for (int i = 0; i < TypeCount*24; i++) uv_mirror[i] = '0;
    for (int i = 0; i < ChunkWidth*ChunkHeight*ChunkWidth; i++) begin
      vox_mirror[i] = '0;
      vox_known[i] = 1'b0;
    end
    for (int f = 0; f < 6; f++)
      for (int i = 0; i < ChunkWidth*PlaneSpan; i++) plane_mirror[f][i] = '0;
    quad_mirror = '0;
    world_mode = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b1);

    phase = 1;
    foreach (directed[i]) begin
      if (directed[i].c == CMD_MESH)
        fill_around(directed[i].x, directed[i].y, directed[i].z, 1'b0);
      if (directed[i].c == CMD_LOAD_VOXEL)
        load_voxel(directed[i].x, directed[i].y, directed[i].z, directed[i].t);
      else begin
        send_word(make_word(directed[i].c, directed[i].x, directed[i].y, directed[i].z,
                            directed[i].f, directed[i].cr, directed[i].t,
                            directed[i].u, directed[i].v), n);
        if (directed[i].count != NoCount && n != directed[i].count) begin
          errors++;
          if (errors <= 10)
            $display("directed row %0d: expected %0d vertices, predicted %0d",
                     i, directed[i].count, n);
        end
      end
    end

    for (int p = 2; p <= 5; p++) begin
      drain();
      phase = p;
      write_mode(p[0] ? 1'b1 : 1'b0);
      repeat (12) random_word();
    end
    drain();

    $display("sent %0d words (%0d mesh), checked %0d vertices over both world modes",
             words_sent, meshes_sent, verts_seen);
    if (errors == 0) begin
      $display("voxel_face_cull_mesher regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("voxel_face_cull_mesher regression: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/vfc_pkg.sv
sv/vfc_store.sv
sv/voxel_face_cull_mesher.sv
tb/sv/tb_voxel_face_cull_mesher.sv
